// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, cause, effect) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, cause, effect)
`endif
`endif

// ----- hw/rtl/knn_pkg.sv -----
// shared types and constants of the nearest neighbour search
`default_nettype none
package knn_pkg;
	localparam int DEF_MAX_DIM = 64;
	localparam int DEF_MAX_K = 8;

	localparam int COORD_W = 32;
	localparam int ID_W = 16;
	localparam int DIST_W = 64;
	localparam int RANK_W = 3;
	localparam int K_W = 4;
	localparam int DIMS_W = 7;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_K_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 1'd1;

	localparam logic [K_W-1:0] K_RESET = 4'd8;
	localparam logic [DIMS_W-1:0] DIMS_RESET = 7'd64;

	// queue between the distance front end and the list back end
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [DIST_W-1:0] sq_dist;
		logic [ID_W-1:0] id;
		logic last_point;
	} cand_t;
endpackage
`default_nettype wire

// ----- hw/rtl/knn_ram.sv -----
// generic single write, single read ram with registered read data
`default_nettype none
module knn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/knn_front.sv -----
// front end: coordinate counter, query store and square-accumulate pipeline
`default_nettype none
module knn_front #(
	parameter int MAX_DIM = knn_pkg::DEF_MAX_DIM
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [knn_pkg::DIMS_W-1:0] dims_in_use,
	input wire logic push,
	output logic full,
	input wire logic command,
	input wire logic [knn_pkg::COORD_W-1:0] coord_value,
	input wire logic [knn_pkg::ID_W-1:0] point_id,
	input wire logic last_coord,
	input wire logic last_point,
	input wire logic [knn_pkg::QUEUE_CW-1:0] q_count,
	output logic q_push,
	output knn_pkg::cand_t q_entry
);
	localparam int AW = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
	localparam int IW = knn_pkg::QUEUE_CW + 1;

	logic [AW-1:0] dim_last;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] idx;
	logic point_end;
	logic accept;
	logic [IW-1:0] inflight;

	logic [knn_pkg::COORD_W-1:0] q_rdata;

	logic v_s1, cand_s1, pe_s1, lp_s1;
	logic [knn_pkg::COORD_W-1:0] coord_s1;
	logic [knn_pkg::ID_W-1:0] id_s1;

	logic v_s2, cand_s2, pe_s2, lp_s2;
	logic [31:0] mag_s2;
	logic [knn_pkg::ID_W-1:0] id_s2;

	logic v_s3, cand_s3, pe_s3, lp_s3;
	logic [63:0] sq_s3;
	logic [knn_pkg::ID_W-1:0] id_s3;

	logic [knn_pkg::DIST_W-1:0] acc_q;
	logic signed [32:0] diff;
	logic [32:0] absval;
	logic [64:0] sum;
	logic [knn_pkg::DIST_W-1:0] sum_sat;

	always_comb begin
		if (dims_in_use == '0) begin
			dim_last = '0;
		end else if (int'(dims_in_use) > MAX_DIM) begin
			dim_last = AW'(MAX_DIM - 1);
		end else begin
			dim_last = AW'(dims_in_use - 7'd1);
		end
	end

	// a counter left beyond a shortened point clamps to its last index
	assign idx = (cnt_q > dim_last) ? dim_last : cnt_q;
	assign point_end = last_coord || (idx == dim_last);

	// every item in flight may take a queue slot
	assign inflight = IW'(q_count) + IW'(v_s1) + IW'(v_s2) + IW'(v_s3);
	assign full = inflight >= IW'(knn_pkg::QUEUE_DEPTH);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= point_end ? '0 : idx + AW'(1);
		end
	end

	knn_ram #(
		.WIDTH(knn_pkg::COORD_W),
		.DEPTH(MAX_DIM)
	) u_query (
		.clk(clk),
		.we(accept && !command),
		.waddr(idx),
		.wdata(coord_value),
		.re(accept && command),
		.raddr(idx),
		.rdata(q_rdata)
	);

	assign diff = $signed({coord_s1[31], coord_s1}) - $signed({q_rdata[31], q_rdata});
	assign absval = diff[32] ? 33'(-diff) : 33'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cand_s1 <= command;
			coord_s1 <= coord_value;
			id_s1 <= point_id;
			pe_s1 <= point_end;
			lp_s1 <= last_point;
		end
		cand_s2 <= cand_s1;
		pe_s2 <= pe_s1;
		lp_s2 <= lp_s1;
		id_s2 <= id_s1;
		mag_s2 <= absval[31:0];
		cand_s3 <= cand_s2;
		pe_s3 <= pe_s2;
		lp_s3 <= lp_s2;
		id_s3 <= id_s2;
		sq_s3 <= 64'(mag_s2) * 64'(mag_s2);
	end

	assign sum = {1'b0, acc_q} + {1'b0, sq_s3};
	assign sum_sat = sum[64] ? '1 : sum[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s3) begin
			if (pe_s3) begin
				acc_q <= '0;
			end else if (cand_s3) begin
				acc_q <= sum_sat;
			end
		end
	end

	assign q_push = v_s3 && cand_s3 && pe_s3;
	assign q_entry.sq_dist = sum_sat;
	assign q_entry.id = id_s3;
	assign q_entry.last_point = lp_s3;
endmodule
`default_nettype wire

// ----- hw/rtl/knn_fifo.sv -----
// short queue of finished candidate distances
`default_nettype none
`include "assert_macros.svh"
module knn_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire knn_pkg::cand_t wentry,
	input wire logic pop,
	output logic empty,
	output knn_pkg::cand_t head,
	output logic [knn_pkg::QUEUE_CW-1:0] count
);
	localparam int DEPTH = knn_pkg::QUEUE_DEPTH;
	localparam int PW = knn_pkg::QUEUE_PW;
	localparam int CW = knn_pkg::QUEUE_CW;

	knn_pkg::cand_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wentry;
		end
	end

	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];
	assign count = count_q;

	`ASSERT_ALWAYS(a_no_overflow, !(push && !pop && (count_q == CW'(DEPTH))))
	`ASSERT_ALWAYS(a_no_underflow, !(pop && (count_q == '0)))
endmodule
`default_nettype wire

// ----- hw/rtl/knn_back.sv -----
// back end: sorted k-best list, compare-and-swap pass and result emission
`default_nettype none
`include "assert_macros.svh"
module knn_back #(
	parameter int MAX_K = knn_pkg::DEF_MAX_K
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [knn_pkg::K_W-1:0] k_in_use,
	input wire logic q_empty,
	input wire knn_pkg::cand_t q_head,
	output logic q_pop,
	output logic empty,
	input wire logic pop,
	output logic [knn_pkg::RANK_W-1:0] rank,
	output logic [knn_pkg::ID_W-1:0] neighbour_id,
	output logic [knn_pkg::DIST_W-1:0] distance_sq,
	output logic slot_valid,
	output logic last
);
	localparam int KW = MAX_K > 1 ? $clog2(MAX_K) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PASS = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [KW-1:0] step_q;
	logic [KW-1:0] cnt_q;
	logic lp_q;
	logic [KW-1:0] w;

	logic [knn_pkg::DIST_W-1:0] dist_q [MAX_K];
	logic [knn_pkg::ID_W-1:0] id_q [MAX_K];
	logic [MAX_K-1:0] valid_q;
	logic [knn_pkg::DIST_W-1:0] dist_d [MAX_K];
	logic [knn_pkg::ID_W-1:0] id_d [MAX_K];
	logic [MAX_K-1:0] valid_d;

	logic offer;
	logic [MAX_K-1:0] repl;
	logic [MAX_K-1:0] swap;
	logic load_out;
	logic clear_all;
	logic out_valid_q;

	// index of the worst slot in use
	always_comb begin
		if (k_in_use == '0) begin
			w = '0;
		end else if (int'(k_in_use) > MAX_K) begin
			w = KW'(MAX_K - 1);
		end else begin
			w = KW'(k_in_use - 4'd1);
		end
	end

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign offer = q_pop && (q_head.sq_dist != '0);
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || pop);
	assign clear_all = load_out && (cnt_q == w);

	always_comb begin
		for (int j = 0; j < MAX_K; j++) begin
			repl[j] = offer && (w == KW'(j)) &&
				(!valid_q[j] || (q_head.sq_dist < dist_q[j]));
		end
		swap[0] = 1'b0;
		for (int j = 1; j < MAX_K; j++) begin
			swap[j] = (state_q == ST_PASS) && (step_q == KW'(j)) && valid_q[j] &&
				(!valid_q[j-1] || (dist_q[j] < dist_q[j-1]));
		end
	end

	// each slot only looks at itself, its two neighbours and the queue head
	always_comb begin
		for (int j = 0; j < MAX_K; j++) begin
			dist_d[j] = dist_q[j];
			id_d[j] = id_q[j];
			valid_d[j] = valid_q[j];
			if (load_out) begin
				if (j < MAX_K - 1) begin
					dist_d[j] = dist_q[j+1];
					id_d[j] = id_q[j+1];
					valid_d[j] = valid_q[j+1];
				end else begin
					valid_d[j] = 1'b0;
				end
			end else if (repl[j]) begin
				dist_d[j] = q_head.sq_dist;
				id_d[j] = q_head.id;
				valid_d[j] = 1'b1;
			end else if ((j > 0) && swap[j]) begin
				dist_d[j] = dist_q[j-1];
				id_d[j] = id_q[j-1];
				valid_d[j] = valid_q[j-1];
			end else if ((j < MAX_K - 1) && swap[j+1]) begin
				dist_d[j] = dist_q[j+1];
				id_d[j] = id_q[j+1];
				valid_d[j] = valid_q[j+1];
			end
		end
		if (clear_all) begin
			valid_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		dist_q <= dist_d;
		id_q <= id_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			cnt_q <= '0;
			lp_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						lp_q <= q_head.last_point;
						cnt_q <= '0;
						if ((|repl) && (w != '0)) begin
							state_q <= ST_PASS;
							step_q <= w;
						end else if (q_head.last_point) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_PASS: begin
					if (step_q == KW'(1)) begin
						state_q <= lp_q ? ST_EMIT : ST_IDLE;
					end else begin
						step_q <= step_q - KW'(1);
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						if (cnt_q == w) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + KW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register, slot 0 of the shifting list is the next rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rank <= knn_pkg::RANK_W'(cnt_q);
			neighbour_id <= valid_q[0] ? id_q[0] : '0;
			distance_sq <= valid_q[0] ? dist_q[0] : '0;
			slot_valid <= valid_q[0];
			last <= (cnt_q == w);
		end
	end

	assign empty = !out_valid_q;

	`ASSERT_ALWAYS(a_one_swap, $onehot0(swap))
	`ASSERT_ALWAYS(a_pass_step, (state_q != ST_PASS) || (step_q != '0))
	`ASSERT_NEXT(a_list_cleared, clear_all, valid_q == '0)
endmodule
`default_nettype wire

// ----- hw/rtl/k_nearest_neighbour_search.sv -----
// top level of the brute force k nearest neighbour search
// A query is loaded first with command 0, one coordinate per transaction, then candidate
// points stream with command 1, one coordinate per transaction. The front end takes one
// coordinate per cycle while full is low and runs it through a three stage square-accumulate
// pipeline (query ram read, difference, 32x32 square) into a saturating 64-bit sum. Each
// finished candidate goes into a four entry queue; the back end takes one entry per cycle
// while it is idle, and a distance that enters the list starts a compare-and-swap pass over
// the slots in use, one slot pair per cycle. At the end of the set the list leaves in rank
// order, one result per cycle while results are popped, through a one entry result register,
// and is then empty again. full is high while the queue entries and the coordinates in the
// three pipeline stages add up to four, so any distance still waiting in the queue holds the
// input off whenever three coordinates are already in the pipeline. The query store is a ram
// of MAX_DIM entries; only entries that were written as query coordinates may be read.
`default_nettype none
module k_nearest_neighbour_search #(
	parameter int MAX_DIM = knn_pkg::DEF_MAX_DIM,
	parameter int MAX_K = knn_pkg::DEF_MAX_K
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [knn_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [knn_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic push,
	output logic full,
	input wire logic command,
	input wire logic [knn_pkg::COORD_W-1:0] coord_value,
	input wire logic [knn_pkg::ID_W-1:0] point_id,
	input wire logic last_coord,
	input wire logic last_point,
	output logic empty,
	input wire logic pop,
	output logic [knn_pkg::RANK_W-1:0] rank,
	output logic [knn_pkg::ID_W-1:0] neighbour_id,
	output logic [knn_pkg::DIST_W-1:0] distance_sq,
	output logic slot_valid,
	output logic last
);
	logic [knn_pkg::K_W-1:0] k_in_use_q;
	logic [knn_pkg::DIMS_W-1:0] dims_in_use_q;

	logic q_push;
	knn_pkg::cand_t q_wentry;
	logic q_pop;
	logic q_empty;
	knn_pkg::cand_t q_head;
	logic [knn_pkg::QUEUE_CW-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_in_use_q <= knn_pkg::K_RESET;
			dims_in_use_q <= knn_pkg::DIMS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				knn_pkg::REG_K_IN_USE: begin
					k_in_use_q <= cfg_data[knn_pkg::K_W-1:0];
				end
				knn_pkg::REG_DIMS_IN_USE: begin
					dims_in_use_q <= cfg_data[knn_pkg::DIMS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	knn_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.dims_in_use(dims_in_use_q),
		.push(push),
		.full(full),
		.command(command),
		.coord_value(coord_value),
		.point_id(point_id),
		.last_coord(last_coord),
		.last_point(last_point),
		.q_count(q_count),
		.q_push(q_push),
		.q_entry(q_wentry)
	);

	knn_fifo u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wentry(q_wentry),
		.pop(q_pop),
		.empty(q_empty),
		.head(q_head),
		.count(q_count)
	);

	knn_back #(
		.MAX_K(MAX_K)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.k_in_use(k_in_use_q),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.rank(rank),
		.neighbour_id(neighbour_id),
		.distance_sq(distance_sq),
		.slot_valid(slot_valid),
		.last(last)
	);
endmodule
`default_nettype wire
